### rtl/lqs_pkg.sv
package lqs_pkg;

  // slot table size and derived index width
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // field widths
  localparam int SLOT_IN_W = 3;
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 4;
  localparam int RAND_W    = 16;
  localparam int QUANT_W   = 8;
  localparam int CLOCK_W   = 24;
  localparam int METRIC_W  = 25;

  // item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // ticket arithmetic
  localparam int TICKET_BASE = 10;
  localparam int TICK_W      = $clog2(TICKET_BASE + 1);
  localparam int TOT_W       = $clog2(TICKET_BASE * NUM_SLOTS + 1);

  localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(2);
  localparam logic [CLOCK_W-1:0] CLOCK_MAX     = '1;

  // controller states
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_LOAD   = 10'b00_0000_0010,
    ST_SUM    = 10'b00_0000_0100,
    ST_START  = 10'b00_0000_1000,
    ST_MOD    = 10'b00_0001_0000,
    ST_SCAN   = 10'b00_0010_0000,
    ST_POINT  = 10'b00_0100_0000,
    ST_APPLY  = 10'b00_1000_0000,
    ST_TURN   = 10'b01_0000_0000,
    ST_RESULT = 10'b10_0000_0000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_slot;
    logic walk_clear;
    logic sum_step;
    logic mod_start;
    logic scan_step;
    logic point_win;
    logic apply;
    logic turn;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;
    logic total_zero;
    logic mod_done;
    logic out_free;
  } status_t;

  // tickets held by a live slot of the given priority
  function automatic logic [TICK_W-1:0] tickets_for(input logic [PRIO_W-1:0] prio);
    logic [TICK_W-1:0] t;
    case (prio)
      PRIO_W'(0), PRIO_W'(1): t = TICK_W'(TICKET_BASE);
      PRIO_W'(2):             t = TICK_W'(TICKET_BASE / 2);
      PRIO_W'(3):             t = TICK_W'(TICKET_BASE / 3);
      PRIO_W'(4):             t = TICK_W'(TICKET_BASE / 4);
      PRIO_W'(5):             t = TICK_W'(TICKET_BASE / 5);
      default:                t = TICK_W'(1);
    endcase
    return t;
  endfunction

endpackage

### rtl/lqs_mod_unit.sv
module lqs_mod_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lqs_pkg::RAND_W-1:0]    dividend,
  input  logic [lqs_pkg::TOT_W-1:0]     divisor,
  output logic [lqs_pkg::TOT_W-1:0]     rem,
  output logic                          done
);

  localparam int CNT_W = $clog2(lqs_pkg::RAND_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [lqs_pkg::RAND_W-1:0]    shreg;
  logic [lqs_pkg::TOT_W:0]       trial;
  logic                          fits;

  // one restoring step: bring in the next dividend bit and subtract if it fits
  assign trial = {rem, shreg[lqs_pkg::RAND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // control of the bit-serial loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(lqs_pkg::RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[lqs_pkg::RAND_W-2:0], 1'b0};
      rem   <= fits ? lqs_pkg::TOT_W'(trial - {1'b0, divisor})
                    : trial[lqs_pkg::TOT_W-1:0];
    end
  end

endmodule

### rtl/lqs_ctrl.sv
module lqs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_ready,
  input  lqs_pkg::status_t sts,
  output lqs_pkg::cmd_t    cmd
);

  lqs_pkg::state_t state;
  lqs_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lqs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == lqs_pkg::ST_IDLE);

  // sequencing of one item
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      lqs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture    = 1'b1;
          cmd.walk_clear = 1'b1;
          state_next     = (in_mode == lqs_pkg::MODE_STEP) ? lqs_pkg::ST_SUM
                                                           : lqs_pkg::ST_LOAD;
        end
      end
      lqs_pkg::ST_LOAD: begin
        cmd.load_slot = 1'b1;
        state_next    = lqs_pkg::ST_RESULT;
      end
      lqs_pkg::ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.walk_last) begin
          state_next = lqs_pkg::ST_START;
        end
      end
      lqs_pkg::ST_START: begin
        if (sts.total_zero) begin
          state_next = lqs_pkg::ST_RESULT;
        end else begin
          cmd.mod_start  = 1'b1;
          cmd.walk_clear = 1'b1;
          state_next     = lqs_pkg::ST_MOD;
        end
      end
      lqs_pkg::ST_MOD: begin
        if (sts.mod_done) begin
          state_next = lqs_pkg::ST_SCAN;
        end
      end
      lqs_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.walk_last) begin
          state_next = lqs_pkg::ST_POINT;
        end
      end
      lqs_pkg::ST_POINT: begin
        cmd.point_win = 1'b1;
        state_next    = lqs_pkg::ST_APPLY;
      end
      lqs_pkg::ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = lqs_pkg::ST_TURN;
      end
      lqs_pkg::ST_TURN: begin
        cmd.turn   = 1'b1;
        state_next = lqs_pkg::ST_RESULT;
      end
      lqs_pkg::ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = lqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lqs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/lqs_datapath.sv
module lqs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  lqs_pkg::cmd_t                     cmd,
  output lqs_pkg::status_t                  sts,
  input  logic                              quantum_length_we,
  input  logic [lqs_pkg::QUANT_W-1:0]       quantum_length,
  input  logic                              mode,
  input  logic [lqs_pkg::SLOT_IN_W-1:0]     slot_index,
  input  logic [lqs_pkg::TIME_W-1:0]        arrival_value,
  input  logic [lqs_pkg::TIME_W-1:0]        burst_value,
  input  logic [lqs_pkg::PRIO_W-1:0]        priority_value,
  input  logic [lqs_pkg::RAND_W-1:0]        random_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lqs_pkg::SLOT_IN_W-1:0]     winner_slot,
  output logic [lqs_pkg::QUANT_W-1:0]       slice_length,
  output logic [lqs_pkg::CLOCK_W-1:0]       clock_now,
  output logic                              finished,
  output logic signed [lqs_pkg::METRIC_W-1:0] turnaround,
  output logic signed [lqs_pkg::METRIC_W-1:0] waiting,
  output logic                              all_done
);

  localparam int SLOT_W  = lqs_pkg::SLOT_W;
  localparam int TIME_W  = lqs_pkg::TIME_W;
  localparam int QUANT_W = lqs_pkg::QUANT_W;
  localparam int CLOCK_W = lqs_pkg::CLOCK_W;
  localparam int MET_W   = lqs_pkg::METRIC_W;
  localparam int TOT_W   = lqs_pkg::TOT_W;

  // slot table
  logic [TIME_W-1:0]          remaining_store [lqs_pkg::NUM_SLOTS];
  logic [TIME_W-1:0]          burst_store     [lqs_pkg::NUM_SLOTS];
  logic [TIME_W-1:0]          arrival_store   [lqs_pkg::NUM_SLOTS];
  logic [lqs_pkg::PRIO_W-1:0] priority_store  [lqs_pkg::NUM_SLOTS];

  logic [CLOCK_W-1:0]           clock_count;
  logic [QUANT_W-1:0]           quantum;

  // captured item
  logic                         mode_q;
  logic [lqs_pkg::SLOT_IN_W-1:0] slot_q;
  logic [TIME_W-1:0]            arrival_q;
  logic [TIME_W-1:0]            burst_q;
  logic [lqs_pkg::PRIO_W-1:0]   prio_q;
  logic [lqs_pkg::RAND_W-1:0]   random_q;

  // walk and lottery working registers
  logic [SLOT_W-1:0]            ptr;
  logic [TOT_W-1:0]             total;
  logic [TOT_W-1:0]             acc;
  logic [SLOT_W-1:0]            win;
  logic                         found;
  logic [QUANT_W-1:0]           slice;
  logic                         fin;
  logic [MET_W-1:0]             turn;

  logic [TOT_W-1:0]             mod_rem;
  logic                         mod_done;

  // read port at the walk pointer
  logic [TIME_W-1:0]            rd_rem;
  logic [TIME_W-1:0]            rd_arr;
  logic [TIME_W-1:0]            rd_burst;
  logic                         live;
  logic [TOT_W-1:0]             tick;
  logic [TOT_W-1:0]             acc_sum;
  logic                         walk_last;
  logic                         slot_ok;
  logic [QUANT_W-1:0]           slice_c;
  logic [TIME_W-1:0]            rem_new;
  logic [CLOCK_W:0]             clock_sum;
  logic                         out_free;

  assign rd_rem    = remaining_store[ptr];
  assign rd_arr    = arrival_store[ptr];
  assign rd_burst  = burst_store[ptr];
  assign live      = (rd_rem != '0);
  assign tick      = live ? TOT_W'(lqs_pkg::tickets_for(priority_store[ptr])) : '0;
  assign acc_sum   = acc + tick;
  assign walk_last = (ptr == SLOT_W'(lqs_pkg::NUM_SLOTS - 1));
  assign slot_ok   = (32'(slot_q) < 32'(lqs_pkg::NUM_SLOTS));

  // slice grant and clock advance for the winner
  assign slice_c   = (rd_rem < TIME_W'(quantum)) ? rd_rem[QUANT_W-1:0] : quantum;
  assign rem_new   = rd_rem - TIME_W'(slice_c);
  assign clock_sum = {1'b0, clock_count} + (CLOCK_W + 1)'(slice_c);

  assign out_free = !out_valid || out_ready;

  assign sts.walk_last  = walk_last;
  assign sts.total_zero = (total == '0);
  assign sts.mod_done   = mod_done;
  assign sts.out_free   = out_free;

  // remainder of the random word over the ticket total
  lqs_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (random_q),
    .divisor  (total),
    .rem      (mod_rem),
    .done     (mod_done)
  );

  // quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= lqs_pkg::QUANTUM_RESET;
    end else if (quantum_length_we) begin
      quantum <= quantum_length;
    end
  end

  // input capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q    <= mode;
      slot_q    <= slot_index;
      arrival_q <= arrival_value;
      burst_q   <= burst_value;
      prio_q    <= priority_value;
      random_q  <= random_word;
    end
  end

  // slot table and scheduler clock
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lqs_pkg::NUM_SLOTS; i++) begin
        remaining_store[i] <= '0;
        burst_store[i]     <= '0;
        arrival_store[i]   <= '0;
        priority_store[i]  <= '0;
      end
      clock_count <= '0;
    end else begin
      if (cmd.load_slot && slot_ok) begin
        arrival_store[SLOT_W'(slot_q)]   <= arrival_q;
        burst_store[SLOT_W'(slot_q)]     <= burst_q;
        remaining_store[SLOT_W'(slot_q)] <= burst_q;
        priority_store[SLOT_W'(slot_q)]  <= prio_q;
      end else if (cmd.apply) begin
        remaining_store[ptr] <= rem_new;
      end
      if (cmd.apply) begin
        clock_count <= clock_sum[CLOCK_W] ? lqs_pkg::CLOCK_MAX : clock_sum[CLOCK_W-1:0];
      end
    end
  end

  // ticket walks: total pass, then winner search
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      total <= '0;
    end else if (cmd.sum_step) begin
      total <= total + tick;
    end

    if (cmd.walk_clear) begin
      ptr   <= '0;
      acc   <= '0;
      found <= 1'b0;
    end else if (cmd.point_win) begin
      ptr <= win;
    end else if (cmd.sum_step || cmd.scan_step) begin
      ptr <= walk_last ? '0 : ptr + SLOT_W'(1);
      if (cmd.scan_step) begin
        acc <= acc_sum;
        if (live && !found && (mod_rem < acc_sum)) begin
          win   <= ptr;
          found <= 1'b1;
        end
      end
    end

    if (cmd.apply) begin
      slice <= slice_c;
      fin   <= (rem_new == '0) && (slice_c != '0);
    end

    if (cmd.turn) begin
      turn <= {1'b0, clock_count} - MET_W'(rd_arr);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      clock_now <= clock_count;
      if ((mode_q == lqs_pkg::MODE_STEP) && (total != '0)) begin
        winner_slot  <= lqs_pkg::SLOT_IN_W'(win);
        slice_length <= slice;
        finished     <= fin;
        turnaround   <= fin ? turn : '0;
        waiting      <= fin ? (turn - MET_W'(rd_burst)) : '0;
        all_done     <= 1'b0;
      end else begin
        winner_slot  <= '0;
        slice_length <= '0;
        finished     <= 1'b0;
        turnaround   <= '0;
        waiting      <= '0;
        all_done     <= (mode_q == lqs_pkg::MODE_STEP);
      end
    end
  end

endmodule

### rtl/lottery_quantum_scheduler_core.sv
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    mode, slot_index, arrival_value, burst_value,
//                                             priority_value, random_word
// out       output     out_valid / out_ready  winner_slot, slice_length, clock_now, finished,
//                                             turnaround, waiting, all_done
// config    input      quantum_length_we      quantum_length
//
// a load item writes its slot and goes to the result; a step item makes two passes
// over the slot table (one slot a cycle) and runs the bit-serial remainder unit
// between them; a step with no live slot skips the remainder unit and the second pass
// one item at a time; in_ready is high only while the controller is idle
// the result register frees the input side: a new item is taken while a result waits
// synchronous active-high reset clears the slot table, the clock and the quantum (to 2)
module lottery_quantum_scheduler_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                quantum_length_we,
  input  logic [lqs_pkg::QUANT_W-1:0]         quantum_length,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [lqs_pkg::SLOT_IN_W-1:0]       slot_index,
  input  logic [lqs_pkg::TIME_W-1:0]          arrival_value,
  input  logic [lqs_pkg::TIME_W-1:0]          burst_value,
  input  logic [lqs_pkg::PRIO_W-1:0]          priority_value,
  input  logic [lqs_pkg::RAND_W-1:0]          random_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lqs_pkg::SLOT_IN_W-1:0]       winner_slot,
  output logic [lqs_pkg::QUANT_W-1:0]         slice_length,
  output logic [lqs_pkg::CLOCK_W-1:0]         clock_now,
  output logic                                finished,
  output logic signed [lqs_pkg::METRIC_W-1:0] turnaround,
  output logic signed [lqs_pkg::METRIC_W-1:0] waiting,
  output logic                                all_done
);

  lqs_pkg::cmd_t    cmd;
  lqs_pkg::status_t sts;

  // sequencer
  lqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (mode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table, lottery arithmetic and result register
  lqs_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .quantum_length_we (quantum_length_we),
    .quantum_length    (quantum_length),
    .mode              (mode),
    .slot_index        (slot_index),
    .arrival_value     (arrival_value),
    .burst_value       (burst_value),
    .priority_value    (priority_value),
    .random_word       (random_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .winner_slot       (winner_slot),
    .slice_length      (slice_length),
    .clock_now         (clock_now),
    .finished          (finished),
    .turnaround        (turnaround),
    .waiting           (waiting),
    .all_done          (all_done)
  );

endmodule

### rtl/lqs_checker.sv
module lqs_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [lqs_pkg::SLOT_IN_W-1:0]       winner_slot,
  input logic [lqs_pkg::QUANT_W-1:0]         slice_length,
  input logic [lqs_pkg::CLOCK_W-1:0]         clock_now,
  input logic                                finished,
  input logic signed [lqs_pkg::METRIC_W-1:0] turnaround,
  input logic signed [lqs_pkg::METRIC_W-1:0] waiting,
  input logic                                all_done
);

  // a stalled result holds its clock value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clock_now))
    else $error("result changed while stalled");

  // a completion always comes with a non-empty slice
  a_fin_slice: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> slice_length != '0 && !all_done)
    else $error("completion without a slice");

  // an idle step grants nothing
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_done |-> slice_length == '0 && winner_slot == '0 && !finished)
    else $error("idle step granted time");

  // metrics are zero unless a slot completed
  a_metrics_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !finished |-> turnaround == '0 && waiting == '0)
    else $error("metrics reported without completion");

  // the clock seen at results never moves backwards
  a_clock_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready ##1 out_valid |-> clock_now >= $past(clock_now))
    else $error("scheduler clock went backwards");

endmodule

bind lottery_quantum_scheduler_core lqs_checker u_lqs_checker (.*);

### tb/lottery_quantum_scheduler_core_tb.sv
`timescale 1ns / 100ps

module lottery_quantum_scheduler_core_tb;

  localparam int   HOLDOFF_CYCLES = 400;
  localparam int   WATCHDOG_LIMIT = 3000;
  localparam int   TAIL_CYCLES    = 60;

  typedef struct {
    logic                          mode;
    logic [lqs_pkg::SLOT_IN_W-1:0] slot;
    logic [lqs_pkg::TIME_W-1:0]    arrival;
    logic [lqs_pkg::TIME_W-1:0]    burst;
    logic [lqs_pkg::PRIO_W-1:0]    prio;
    logic [lqs_pkg::RAND_W-1:0]    rand_word;
  } sched_item_t;

  typedef struct {
    logic [lqs_pkg::SLOT_IN_W-1:0]       winner;
    logic [lqs_pkg::QUANT_W-1:0]         slice;
    logic [lqs_pkg::CLOCK_W-1:0]         clk_now;
    logic                                fin;
    logic signed [lqs_pkg::METRIC_W-1:0] turn;
    logic signed [lqs_pkg::METRIC_W-1:0] wait_t;
    logic                                done;
  } sched_result_t;

  // dut signals
  logic                                clk = 1'b0;
  logic                                rst;
  logic                                quantum_length_we;
  logic [lqs_pkg::QUANT_W-1:0]         quantum_length;
  logic                                in_valid;
  logic                                in_ready;
  logic                                mode;
  logic [lqs_pkg::SLOT_IN_W-1:0]       slot_index;
  logic [lqs_pkg::TIME_W-1:0]          arrival_value;
  logic [lqs_pkg::TIME_W-1:0]          burst_value;
  logic [lqs_pkg::PRIO_W-1:0]          priority_value;
  logic [lqs_pkg::RAND_W-1:0]          random_word;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [lqs_pkg::SLOT_IN_W-1:0]       winner_slot;
  logic [lqs_pkg::QUANT_W-1:0]         slice_length;
  logic [lqs_pkg::CLOCK_W-1:0]         clock_now;
  logic                                finished;
  logic signed [lqs_pkg::METRIC_W-1:0] turnaround;
  logic signed [lqs_pkg::METRIC_W-1:0] waiting;
  logic                                all_done;

  // scheduler state as the testbench sees it
  logic [lqs_pkg::TIME_W-1:0]  slot_remaining [lqs_pkg::NUM_SLOTS];
  logic [lqs_pkg::TIME_W-1:0]  slot_burst     [lqs_pkg::NUM_SLOTS];
  logic [lqs_pkg::TIME_W-1:0]  slot_arrival   [lqs_pkg::NUM_SLOTS];
  logic [lqs_pkg::PRIO_W-1:0]  slot_priority  [lqs_pkg::NUM_SLOTS];
  logic [lqs_pkg::CLOCK_W-1:0] sched_clock;
  logic [lqs_pkg::QUANT_W-1:0] quantum_now;

  sched_result_t pending_results[$];

  // run control and bookkeeping
  bit source_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int holdoff_requests = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;
  int stall_cycles = 0;
  int items_sent = 0;
  int results_seen = 0;
  int error_count = 0;
  int load_count = 0;
  int draw_count = 0;
  int completion_count = 0;
  int empty_draw_count = 0;
  int negative_turn_count = 0;
  int random_quantum = 0;

  lottery_quantum_scheduler_core u_top (
    .clk               (clk),
    .rst               (rst),
    .quantum_length_we (quantum_length_we),
    .quantum_length    (quantum_length),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .slot_index        (slot_index),
    .arrival_value     (arrival_value),
    .burst_value       (burst_value),
    .priority_value    (priority_value),
    .random_word       (random_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .winner_slot       (winner_slot),
    .slice_length      (slice_length),
    .clock_now         (clock_now),
    .finished          (finished),
    .turnaround        (turnaround),
    .waiting           (waiting),
    .all_done          (all_done)
  );

  always #10 clk = ~clk;

  // tickets held by a live slot
  function automatic int unsigned ticket_share(input logic [lqs_pkg::PRIO_W-1:0] prio);
    int unsigned divisor;
    int unsigned share;
    divisor = (prio == 0) ? 1 : 32'(prio);
    share = lqs_pkg::TICKET_BASE / divisor;
    return (share == 0) ? 1 : share;
  endfunction

  function automatic int live_slots();
    int n;
    n = 0;
    for (int i = 0; i < lqs_pkg::NUM_SLOTS; i++) begin
      if (slot_remaining[i] != 0) n++;
    end
    return n;
  endfunction

  // advance the scheduler state by one item and return the result it causes
  function automatic sched_result_t predict_lottery(input sched_item_t it);
    sched_result_t r;
    int unsigned total;
    int unsigned draw_no;
    int unsigned acc;
    int unsigned slice_v;
    int unsigned clk_sum;
    int win;
    int turn_v;
    int wait_v;
    r = '{default: '0};
    if (it.mode == lqs_pkg::MODE_LOAD) begin
      if (it.slot < lqs_pkg::NUM_SLOTS) begin
        slot_arrival[it.slot]   = it.arrival;
        slot_burst[it.slot]     = it.burst;
        slot_remaining[it.slot] = it.burst;
        slot_priority[it.slot]  = it.prio;
      end
      load_count++;
      r.clk_now = sched_clock;
      return r;
    end
    draw_count++;
    total = 0;
    for (int i = 0; i < lqs_pkg::NUM_SLOTS; i++) begin
      if (slot_remaining[i] != 0) total += ticket_share(slot_priority[i]);
    end
    // empty table: nothing moves
    if (total == 0) begin
      empty_draw_count++;
      r.done = 1'b1;
      r.clk_now = sched_clock;
      return r;
    end
    // first live slot whose running ticket sum reaches the draw
    draw_no = 1 + it.rand_word % total;
    acc = 0;
    win = 0;
    for (int i = 0; i < lqs_pkg::NUM_SLOTS; i++) begin
      if (slot_remaining[i] != 0) begin
        acc += ticket_share(slot_priority[i]);
        if (draw_no <= acc) begin
          win = i;
          break;
        end
      end
    end
    slice_v = (slot_remaining[win] < lqs_pkg::TIME_W'(quantum_now)) ?
              32'(slot_remaining[win]) : 32'(quantum_now);
    slot_remaining[win] = slot_remaining[win] - slice_v[lqs_pkg::TIME_W-1:0];
    clk_sum = 32'(sched_clock) + slice_v;
    sched_clock = (clk_sum > 32'(lqs_pkg::CLOCK_MAX)) ? lqs_pkg::CLOCK_MAX
                                                      : clk_sum[lqs_pkg::CLOCK_W-1:0];
    r.winner  = win[lqs_pkg::SLOT_IN_W-1:0];
    r.slice   = slice_v[lqs_pkg::QUANT_W-1:0];
    r.clk_now = sched_clock;
    if (slot_remaining[win] == 0 && slice_v != 0) begin
      turn_v = int'(sched_clock) - int'(slot_arrival[win]);
      wait_v = turn_v - int'(slot_burst[win]);
      r.fin    = 1'b1;
      r.turn   = turn_v[lqs_pkg::METRIC_W-1:0];
      r.wait_t = wait_v[lqs_pkg::METRIC_W-1:0];
      completion_count++;
      if (turn_v < 0) negative_turn_count++;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at result %0d: got %h, expected %h",
             field, results_seen, got, want);
    error_count++;
  endtask

  // offer one item, hold it until the transfer, then record its expected result
  task automatic send_item(input sched_item_t it);
    int gap;
    sched_result_t expected;
    gap = 0;
    if (source_gaps && $urandom_range(0, 99) < 14) gap = $urandom_range(1, 48);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= it.mode;
    slot_index     <= it.slot;
    arrival_value  <= it.arrival;
    burst_value    <= it.burst;
    priority_value <= it.prio;
    random_word    <= it.rand_word;
    do @(posedge clk); while (!in_ready);
    expected = predict_lottery(it);
    pending_results.insert(pending_results.size(), expected);
    items_sent++;
  endtask

  task automatic load_slot(input int slot, input int arrival, input int burst, input int prio);
    sched_item_t it;
    it.mode      = lqs_pkg::MODE_LOAD;
    it.slot      = slot[lqs_pkg::SLOT_IN_W-1:0];
    it.arrival   = arrival[lqs_pkg::TIME_W-1:0];
    it.burst     = burst[lqs_pkg::TIME_W-1:0];
    it.prio      = prio[lqs_pkg::PRIO_W-1:0];
    it.rand_word = lqs_pkg::RAND_W'($urandom_range(0, 65535));
    send_item(it);
  endtask

  // unused fields of a draw carry noise
  task automatic run_draw(input int word);
    sched_item_t it;
    it.mode      = lqs_pkg::MODE_STEP;
    it.slot      = lqs_pkg::SLOT_IN_W'($urandom_range(0, 7));
    it.arrival   = lqs_pkg::TIME_W'($urandom_range(0, 65535));
    it.burst     = lqs_pkg::TIME_W'($urandom_range(0, 65535));
    it.prio      = lqs_pkg::PRIO_W'($urandom_range(0, 15));
    it.rand_word = word[lqs_pkg::RAND_W-1:0];
    send_item(it);
  endtask

  // sender stops and waits for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_quantum(input int value);
    @(posedge clk);
    quantum_length_we <= 1'b1;
    quantum_length    <= value[lqs_pkg::QUANT_W-1:0];
    @(posedge clk);
    quantum_length_we <= 1'b0;
    quantum_now = value[lqs_pkg::QUANT_W-1:0];
  endtask

  // mostly finishable loads followed by draws, with some odd bursts mixed in
  task automatic random_work();
    int pick;
    int burst;
    int arrival;
    int loads;
    pick = $urandom_range(0, 99);
    if ((live_slots() == 0 && pick < 70) || (live_slots() != 0 && pick < 25)) begin
      loads = $urandom_range(1, 4);
      repeat (loads) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) burst = 0;
        else if (pick < 14) burst = $urandom_range(0, 65535);
        else if (pick < 17) burst = 65535;
        else burst = $urandom_range(1, 24);
        arrival = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 65535)
                                               : $urandom_range(0, 255);
        load_slot($urandom_range(0, 7), arrival, burst, $urandom_range(0, 15));
      end
    end else begin
      run_draw($urandom_range(0, 65535));
    end
  endtask

  task automatic random_items(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_work();
  endtask

  // ---------------- tests ----------------

  // draws against an empty table and a zero-burst load
  task automatic test_empty_table();
    run_draw(0);
    load_slot(0, 16'h1234, 0, 0);
    run_draw(16'hFFFF);
  endtask

  // one low-priority process arriving late, so turnaround goes negative
  task automatic test_single_process();
    load_slot(7, 16'hFFFF, 3, 15);
    run_draw(16'hFFFF);
    run_draw(0);
  endtask

  // several priorities sharing the lottery, draws at the word extremes
  task automatic test_mixed_priorities();
    load_slot(3, 0, 16'hFFFF, 1);
    load_slot(5, 100, 4, 2);
    load_slot(6, 7, 5, 5);
    load_slot(1, 16'h00FF, 2, 4);
    run_draw(0);
    run_draw(16'hFFFF);
    run_draw(16'h5555);
    run_draw(16'hAAAA);
    run_draw(16'h8000);
  endtask

  // zero quantum stalls progress; the largest and smallest quanta
  task automatic test_quantum_extremes();
    drain_results();
    write_quantum(0);
    run_draw(16'h0001);
    run_draw(16'hFFFE);
    drain_results();
    write_quantum(255);
    run_draw(0);
    run_draw(16'h7FFF);
    drain_results();
    write_quantum(1);
    run_draw(16'h3C3C);
    run_draw(16'hC3C3);
  endtask

  // random traffic under a run of quantum settings
  task automatic test_random_traffic();
    int quanta[4];
    random_quantum = $urandom_range(3, 16);
    quanta = '{1, 255, random_quantum, 2};
    foreach (quanta[q]) begin
      drain_results();
      write_quantum(quanta[q]);
      random_items(110);
    end
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_holdoff();
    drain_results();
    holdoff_requests <= holdoff_requests + 1;
    random_items(10);
    drain_results();
  endtask

  // no idling on either side
  task automatic test_unbroken_stream();
    drain_results();
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    random_items(80);
    drain_results();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // ---------------- processes ----------------

  // receiver: random stalls, with a long counted hold-off on request
  always @(posedge clk) begin
    if (holdoff_served != holdoff_requests) begin
      holdoff_served <= holdoff_requests;
      holdoff_left   <= HOLDOFF_CYCLES;
      out_ready      <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else if (sink_stalls) begin
      out_ready <= ($urandom_range(0, 99) >= 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("result %0d arrived with nothing outstanding", results_seen);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (winner_slot !== want.winner)
          report_mismatch("winner_slot", 32'(winner_slot), 32'(want.winner));
        if (slice_length !== want.slice)
          report_mismatch("slice_length", 32'(slice_length), 32'(want.slice));
        if (clock_now !== want.clk_now)
          report_mismatch("clock_now", 32'(clock_now), 32'(want.clk_now));
        if (finished !== want.fin)
          report_mismatch("finished", 32'(finished), 32'(want.fin));
        if (turnaround !== want.turn)
          report_mismatch("turnaround", 32'(turnaround), 32'(want.turn));
        if (waiting !== want.wait_t)
          report_mismatch("waiting", 32'(waiting), 32'(want.wait_t));
        if (all_done !== want.done)
          report_mismatch("all_done", 32'(all_done), 32'(want.done));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, pending_results.size());
      $display("lottery_quantum_scheduler_core test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst               = 1'b1;
    quantum_length_we = 1'b0;
    quantum_length    = '0;
    in_valid          = 1'b0;
    mode              = lqs_pkg::MODE_LOAD;
    slot_index        = '0;
    arrival_value     = '0;
    burst_value       = '0;
    priority_value    = '0;
    random_word       = '0;
    for (int i = 0; i < lqs_pkg::NUM_SLOTS; i++) begin
      slot_remaining[i] = '0;
      slot_burst[i]     = '0;
      slot_arrival[i]   = '0;
      slot_priority[i]  = '0;
    end
    sched_clock = '0;
    quantum_now = lqs_pkg::QUANTUM_RESET;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_single_process();
    test_mixed_priorities();
    test_quantum_extremes();
    test_random_traffic();
    test_output_holdoff();
    test_unbroken_stream();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transfers: %0d slot loads, %0d draws (%0d empty-table draws)",
             items_sent, load_count, draw_count, empty_draw_count);
    $display("%0d processes completed (%0d with negative turnaround); quanta 0/1/2/255/%0d",
             completion_count, negative_turn_count, random_quantum);
    if (error_count == 0) begin
      $display("lottery_quantum_scheduler_core test passed");
    end else begin
      $display("lottery_quantum_scheduler_core test failed");
    end
    $finish;
  end

endmodule
